[sv/wlaniep_pkg.sv]
// wlaniep_pkg: shared widths, element codes and result type of the
// information element parser; no dependencies
`default_nettype none

package wlaniep_pkg;

    localparam int LENGTH_WIDTH = 16;
    localparam int RFIFO_DEPTH  = 4;
    localparam int RFIFO_AW     = $clog2(RFIFO_DEPTH);

    localparam logic [7:0] TAG_SSID   = 8'd0;
    localparam logic [7:0] TAG_RSN    = 8'd48;
    localparam logic [7:0] TAG_HT     = 8'd61;
    localparam logic [7:0] TAG_VHT    = 8'd192;
    localparam logic [7:0] TAG_VENDOR = 8'd221;

    localparam logic [7:0] OUI_LEN      = 8'd4;
    localparam logic [7:0] HT_SEC_IDX   = 8'd1;
    localparam logic [1:0] HT_SEC_MASK  = 2'b11;
    localparam logic [1:0] HT_SEC_ABOVE = 2'd1;
    localparam logic [1:0] HT_SEC_BELOW = 2'd3;
    localparam logic [7:0] VHT_W80      = 8'd1;
    localparam logic [7:0] VHT_W160     = 8'd2;

    localparam logic [7:0] BW_40  = 8'd40;
    localparam logic [7:0] BW_80  = 8'd80;
    localparam logic [7:0] BW_160 = 8'd160;
    localparam logic [7:0] BW_RESET = 8'd20;

    localparam logic [1:0] SEC_OPEN = 2'd0;
    localparam logic [1:0] SEC_WPA  = 2'd1;
    localparam logic [1:0] SEC_RSN  = 2'd2;

    localparam logic [3:0][7:0] WPA_OUI = {8'h01, 8'hf2, 8'h50, 8'h00};

    typedef struct packed {
        logic       ssid_valid;
        logic [7:0] ssid_char;
        logic       ssid_restart;
        logic       summary_valid;
        logic [1:0] security_class;
        logic [7:0] bandwidth_mhz;
        logic       ssid_seen;
        logic       final_result;
    } t_result;

endpackage

`default_nettype wire

[sv/wlaniep_in_if.sv]
// wlaniep_in_if: request channel carrying one buffer byte
// depends on wlaniep_pkg
`default_nettype none

interface wlaniep_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [7:0]                             data_byte;
    logic [wlaniep_pkg::LENGTH_WIDTH-1:0]   buffer_length;
    logic                                   last_byte;

    modport source (output valid, data_byte, buffer_length, last_byte, input ready);
    modport sink   (input valid, data_byte, buffer_length, last_byte, output ready);
endinterface

`default_nettype wire

[sv/wlaniep_out_if.sv]
// wlaniep_out_if: result channel of the parser, ssid bytes and summaries
// no dependencies
`default_nettype none

interface wlaniep_out_if;
    logic       valid;
    logic       ready;
    logic       ssid_valid;
    logic [7:0] ssid_char;
    logic       ssid_restart;
    logic       summary_valid;
    logic [1:0] security_class;
    logic [7:0] bandwidth_mhz;
    logic       ssid_seen;
    logic       final_result;

    modport source (output valid, ssid_valid, ssid_char, ssid_restart, summary_valid,
                    security_class, bandwidth_mhz, ssid_seen, final_result,
                    input ready);
    modport sink   (input valid, ssid_valid, ssid_char, ssid_restart, summary_valid,
                    security_class, bandwidth_mhz, ssid_seen, final_result,
                    output ready);
endinterface

`default_nettype wire

[sv/wlaniep_core.sv]
// wlaniep_core: element header tracking and per-byte result generation
// depends on wlaniep_pkg
`default_nettype none

module wlaniep_core (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_step,
    input  wire logic [7:0]                           i_byte,
    input  wire logic [wlaniep_pkg::LENGTH_WIDTH-1:0] i_blen,
    input  wire logic                                 i_last,
    input  wire logic [7:0]                           i_default_bw,
    output      logic [1:0]                           o_count,
    output      wlaniep_pkg::t_result                 o_first,
    output      wlaniep_pkg::t_result                 o_second
);
    import wlaniep_pkg::*;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_PAY
    } t_phase;

    localparam int LW = LENGTH_WIDTH;

    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_pos, n_pos;
    logic [LW-1:0] r_start, n_start;
    logic [7:0]    r_tag, n_tag;
    logic [7:0]    r_len, n_len;
    logic [7:0]    r_pidx, n_pidx;
    logic          r_oui, n_oui;
    logic          r_rsn, n_rsn;
    logic          r_wpa, n_wpa;
    logic [7:0]    r_bw, n_bw;
    logic          r_ssid, n_ssid;
    logic          r_stop, n_stop;

    logic [LW:0]   pos_p2;
    logic [LW:0]   elem_end;
    logic [LW:0]   blen_x;
    logic [8:0]    pidx_p1;
    logic          oui_ok;
    logic          ssid_out;
    logic          restart;
    t_result       ssid_res;
    t_result       sum_res;

    assign blen_x   = {1'b0, i_blen};
    assign pos_p2   = {1'b0, r_pos} + (LW+1)'(2);
    assign elem_end = {1'b0, r_start} + (LW+1)'(2) + (LW+1)'(i_byte);
    assign pidx_p1  = {1'b0, r_pidx} + 9'd1;
    assign oui_ok   = r_oui && (i_byte == WPA_OUI[r_pidx[1:0]]);

    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_start  = r_start;
        n_tag    = r_tag;
        n_len    = r_len;
        n_pidx   = r_pidx;
        n_oui    = r_oui;
        n_rsn    = r_rsn;
        n_wpa    = r_wpa;
        n_bw     = (r_pos == '0) ? i_default_bw : r_bw;
        n_ssid   = r_ssid;
        n_stop   = r_stop;
        ssid_out = 1'b0;
        restart  = 1'b0;

        if (!r_stop) begin
            unique case (r_phase)
                PH_TAG: begin
                    if (pos_p2 > blen_x) begin
                        n_stop = 1'b1;
                    end else begin
                        n_tag   = i_byte;
                        n_start = r_pos;
                        n_phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_len = i_byte;
                    if (elem_end > blen_x) begin
                        n_stop = 1'b1;
                    end else begin
                        if (r_tag == TAG_RSN) n_rsn = 1'b1;
                        if (r_tag == TAG_SSID && i_byte != 8'd0) n_ssid = 1'b1;
                        n_oui   = 1'b1;
                        n_pidx  = 8'd0;
                        n_phase = (i_byte == 8'd0) ? PH_TAG : PH_PAY;
                    end
                end
                PH_PAY: begin
                    case (r_tag)
                        TAG_SSID: begin
                            ssid_out = 1'b1;
                            restart  = (r_pidx == 8'd0);
                        end
                        TAG_VENDOR: begin
                            if (r_len >= OUI_LEN && r_pidx < OUI_LEN) begin
                                n_oui = oui_ok;
                                if (r_pidx == OUI_LEN - 8'd1 && oui_ok) n_wpa = 1'b1;
                            end
                        end
                        TAG_HT: begin
                            if (r_pidx == HT_SEC_IDX &&
                                ((i_byte[1:0] & HT_SEC_MASK) == HT_SEC_ABOVE ||
                                 (i_byte[1:0] & HT_SEC_MASK) == HT_SEC_BELOW)) begin
                                n_bw = BW_40;
                            end
                        end
                        TAG_VHT: begin
                            if (r_pidx == 8'd0) begin
                                if (i_byte == VHT_W80) n_bw = BW_80;
                                else if (i_byte == VHT_W160) n_bw = BW_160;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (pidx_p1 >= {1'b0, r_len}) begin
                        n_phase = PH_TAG;
                        n_pidx  = 8'd0;
                    end else begin
                        n_pidx = pidx_p1[7:0];
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase
        end

        if (r_pos != '1) n_pos = r_pos + LW'(1);

        ssid_res              = '0;
        ssid_res.ssid_valid   = 1'b1;
        ssid_res.ssid_char    = i_byte;
        ssid_res.ssid_restart = restart;
        ssid_res.final_result = !i_last;

        sum_res                = '0;
        sum_res.summary_valid  = 1'b1;
        sum_res.security_class = n_rsn ? SEC_RSN : (n_wpa ? SEC_WPA : SEC_OPEN);
        sum_res.bandwidth_mhz  = n_bw;
        sum_res.ssid_seen      = n_ssid;
        sum_res.final_result   = 1'b1;

        if (i_last) begin
            n_phase = PH_TAG;
            n_pos   = '0;
            n_start = '0;
            n_tag   = 8'd0;
            n_len   = 8'd0;
            n_pidx  = 8'd0;
            n_oui   = 1'b1;
            n_rsn   = 1'b0;
            n_wpa   = 1'b0;
            n_bw    = i_default_bw;
            n_ssid  = 1'b0;
            n_stop  = 1'b0;
        end
    end

    assign o_count  = {1'b0, ssid_out} + {1'b0, i_last};
    assign o_first  = ssid_out ? ssid_res : sum_res;
    assign o_second = sum_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TAG;
            r_pos   <= '0;
            r_start <= '0;
            r_tag   <= 8'd0;
            r_len   <= 8'd0;
            r_pidx  <= 8'd0;
            r_oui   <= 1'b1;
            r_rsn   <= 1'b0;
            r_wpa   <= 1'b0;
            r_bw    <= BW_RESET;
            r_ssid  <= 1'b0;
            r_stop  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_tag   <= n_tag;
            r_len   <= n_len;
            r_pidx  <= n_pidx;
            r_oui   <= n_oui;
            r_rsn   <= n_rsn;
            r_wpa   <= n_wpa;
            r_bw    <= n_bw;
            r_ssid  <= n_ssid;
            r_stop  <= n_stop;
        end
    end

endmodule

`default_nettype wire

[sv/wlaniep_rfifo.sv]
// wlaniep_rfifo: small result queue taking up to two results per cycle
// depends on wlaniep_pkg
`default_nettype none

module wlaniep_rfifo (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [1:0]           i_push_count,
    input  wire wlaniep_pkg::t_result i_first,
    input  wire wlaniep_pkg::t_result i_second,
    input  wire logic                 i_pop,
    output      logic                 o_room,
    output      logic                 o_valid,
    output      wlaniep_pkg::t_result o_head
);
    import wlaniep_pkg::*;

    t_result               r_mem [RFIFO_DEPTH];
    logic [RFIFO_AW-1:0]   r_wp, n_wp;
    logic [RFIFO_AW-1:0]   r_rp, n_rp;
    logic [RFIFO_AW:0]     r_cnt, n_cnt;
    logic                  do_pop;
    logic [RFIFO_AW-1:0]   wp_p1;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign wp_p1   = r_wp + RFIFO_AW'(1);
    assign n_wp    = r_wp + RFIFO_AW'(i_push_count);
    assign n_rp    = r_rp + RFIFO_AW'(do_pop);
    assign n_cnt   = r_cnt + (RFIFO_AW+1)'(i_push_count) - (RFIFO_AW+1)'(do_pop);
    assign o_room  = r_cnt <= (RFIFO_AW+1)'(RFIFO_DEPTH - 2);
    assign o_valid = r_cnt != '0;
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) r_mem[r_wp] <= i_first;
        if (i_push_count == 2'd2) r_mem[wp_p1] <= i_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[sv/wlan_info_element_parser.sv]
// wlan_info_element_parser: top level with input register, parser core and result queue
// depends on wlaniep_pkg, wlaniep_in_if, wlaniep_out_if, wlaniep_core, wlaniep_rfifo
//
//   port         dir   handshake      carries
//   i_in         in    valid/ready    data_byte, buffer_length, last_byte
//   o_out        out   valid/ready    ssid byte or end of buffer summary
//   i_cfg_wr_*   in    write enable   default_bandwidth_mhz
//
// one request per cycle while the queue has room; results pass input register and queue
// a byte with both an ssid result and a summary delivers them as two output transfers
// the input register advances while the four-entry result queue holds at most two
// reset clears the parse state and sets the default bandwidth to 20
`default_nettype none

module wlan_info_element_parser (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wlaniep_in_if.sink  i_in,
    wlaniep_out_if.source o_out,
    input  wire logic       i_cfg_wr_en,
    input  wire logic [7:0] i_cfg_wr_data
);
    import wlaniep_pkg::*;

    logic                    r_in_valid;
    logic [7:0]              r_byte;
    logic [LENGTH_WIDTH-1:0] r_blen;
    logic                    r_last;
    logic [7:0]              r_default_bw;

    logic                    room;
    logic                    advance;
    logic [1:0]              res_count;
    logic [1:0]              push_count;
    t_result                 res_first;
    t_result                 res_second;
    t_result                 head;
    logic                    head_valid;

    assign advance    = r_in_valid && room;
    assign i_in.ready = !r_in_valid || advance;
    assign push_count = advance ? res_count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_default_bw <= BW_RESET;
        end else begin
            if (i_in.ready) r_in_valid <= i_in.valid;
            if (i_cfg_wr_en) r_default_bw <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
            r_blen <= i_in.buffer_length;
            r_last <= i_in.last_byte;
        end
    end

    wlaniep_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_byte),
        .i_blen       (r_blen),
        .i_last       (r_last),
        .i_default_bw (r_default_bw),
        .o_count      (res_count),
        .o_first      (res_first),
        .o_second     (res_second)
    );

    wlaniep_rfifo u_rfifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_first      (res_first),
        .i_second     (res_second),
        .i_pop        (o_out.ready),
        .o_room       (room),
        .o_valid      (head_valid),
        .o_head       (head)
    );

    assign o_out.valid          = head_valid;
    assign o_out.ssid_valid     = head.ssid_valid;
    assign o_out.ssid_char      = head.ssid_char;
    assign o_out.ssid_restart   = head.ssid_restart;
    assign o_out.summary_valid  = head.summary_valid;
    assign o_out.security_class = head.security_class;
    assign o_out.bandwidth_mhz  = head.bandwidth_mhz;
    assign o_out.ssid_seen      = head.ssid_seen;
    assign o_out.final_result   = head.final_result;

endmodule

`default_nettype wire
